// ===== sv/lsp_pkg.sv =====
`default_nettype none

package lsp_pkg;

  // Fixed widths of the request and result fields.
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_TOP    = 3'd3,
    ACT_BOTTOM = 3'd4,
    ACT_DUMP   = 3'd5,
    ACT_STATUS = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY_ERR = 2'd1,
    STAT_FULL_ERR  = 2'd2,
    STAT_POS_ERR   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  // Occupancy flags reported with every result word.
  typedef struct packed {
    logic               is_empty;
    logic               is_full;
    logic [COUNT_W-1:0] count;
  } flags_t;

endpackage

`default_nettype wire

// ===== sv/lsp_ram.sv =====
`default_nettype none

module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/lsp_flags.sv =====
`default_nettype none

module lsp_flags #(
  parameter int DEPTH = 16
) (
  input  wire logic [$clog2(DEPTH+1)-1:0] fill_i,
  input  wire logic [lsp_pkg::CAP_W-1:0]  capacity_i,
  output lsp_pkg::flags_t                 flags_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > lsp_pkg::CAP_W) ? CNT_W : lsp_pkg::CAP_W;

  logic [CW-1:0] cap_w;
  logic [CW-1:0] fill_w;
  logic [CW-1:0] eff_cap;

  assign cap_w  = CW'(capacity_i);
  assign fill_w = CW'(fill_i);

  // A capacity of zero acts as one, and one above the depth acts as the depth.
  always_comb begin
    if (cap_w == '0) begin
      eff_cap = CW'(1);
    end else if (cap_w > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign flags_o.is_empty = (fill_i == '0);
  assign flags_o.is_full  = (fill_w >= eff_cap);
  assign flags_o.count    = lsp_pkg::COUNT_W'(fill_i);

endmodule

`default_nettype wire

// ===== sv/lifo_stack_with_peek_core.sv =====
`default_nettype none
// Push, status and every error load their result word into the output register on acceptance;
// pop, peek, top and bottom first read the memory, then load it once the output register is free.
// Throughput: one request at a time; a dump of n entries streams n words, one per cycle after
// the first read while the receiver does not stall, as the single read port walks down from
// the top entry. Reset clears the entry count and the control state and sets the capacity to
// 10; the entry memory is not cleared, since an entry is read only after it was pushed.

module lifo_stack_with_peek_core #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lsp_pkg::CAP_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [2:0]                      action_i,
  input  wire logic signed [lsp_pkg::DATA_W-1:0] push_value_i,
  input  wire logic [lsp_pkg::POS_W-1:0]       position_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [lsp_pkg::DATA_W-1:0]    data_o,
  output logic [1:0]                           status_o,
  output logic                                 is_empty_o,
  output logic                                 is_full_o,
  output logic [lsp_pkg::COUNT_W-1:0]          count_o,
  output logic                                 last_o
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = (CNT_W > lsp_pkg::POS_W) ? CNT_W : lsp_pkg::POS_W;

  // Capacity register, set via the configuration port; the user must do so only while idle (unenforced).
  logic [lsp_pkg::CAP_W-1:0] cap_q;

  // Control state. The fill count and the capacity register are the only architectural state outside the memory.
  lsp_pkg::state_e    state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               dump_q, dump_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;

  // Output register: it holds one finished word until the receiver takes it.
  logic                               out_valid_q, out_valid_d;
  logic signed [lsp_pkg::DATA_W-1:0]  out_data_q, out_data_d;
  lsp_pkg::status_e                   out_status_q, out_status_d;
  lsp_pkg::flags_t                    out_flags_q, out_flags_d;
  logic                               out_last_q, out_last_d;

  // Memory port.
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  lsp_pkg::flags_t flags_now;
  lsp_pkg::flags_t flags_next;

  logic                              in_acc;
  logic                              out_free;
  logic [CW-1:0]                     cw_fill;
  logic [CW-1:0]                     cw_pos;
  logic [ADDR_W-1:0]                 top_addr;
  logic [ADDR_W-1:0]                 peek_addr;
  logic signed [lsp_pkg::DATA_W-1:0] rd_word;

  lsp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Flags of the count before the request decide whether a push fits.
  lsp_flags #(
    .DEPTH (DEPTH)
  ) u_flags_now (
    .fill_i     (fill_q),
    .capacity_i (cap_q),
    .flags_o    (flags_now)
  );

  // Flags of the count after the request are the ones that are reported.
  lsp_flags #(
    .DEPTH (DEPTH)
  ) u_flags_next (
    .fill_i     (fill_d),
    .capacity_i (cap_q),
    .flags_o    (flags_next)
  );

  // A request is taken only when idle and when the output register is free or is
  // being emptied in this cycle, so an immediate result always has a place to go.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != lsp_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cw_fill   = CW'(fill_q);
  assign cw_pos    = CW'(position_i);
  assign top_addr  = ADDR_W'(fill_q - CNT_W'(1));
  assign peek_addr = ADDR_W'(cw_fill - cw_pos);

  // The stored word is sign-extended from its own width, or cut, to the 32-bit field.
  assign rd_word = lsp_pkg::DATA_W'($signed(ram_rdata));

  always_comb begin
    logic             imm_v;
    lsp_pkg::status_e imm_s;

    imm_v = 1'b0;
    imm_s = lsp_pkg::STAT_OK;

    state_d = state_q;
    fill_d  = fill_q;
    dump_d  = dump_q;
    idx_d   = idx_q;

    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(fill_q);
    ram_wdata = WORD_BITS'(push_value_i);
    ram_re    = 1'b0;
    ram_raddr = top_addr;

    // A word that is taken leaves the register unless a new one is loaded below.
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_flags_d  = out_flags_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      lsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          dump_d = 1'b0;
          unique case (lsp_pkg::action_e'(action_i))
            lsp_pkg::ACT_PUSH: begin
              imm_v = 1'b1;
              if (flags_now.is_full) begin
                imm_s = lsp_pkg::STAT_FULL_ERR;
              end else begin
                ram_we = 1'b1;
                fill_d = fill_q + CNT_W'(1);
              end
            end
            lsp_pkg::ACT_POP: begin
              if (flags_now.is_empty) begin
                imm_v = 1'b1;
                imm_s = lsp_pkg::STAT_EMPTY_ERR;
              end else begin
                ram_re  = 1'b1;
                fill_d  = fill_q - CNT_W'(1);
                state_d = lsp_pkg::ST_READ;
              end
            end
            lsp_pkg::ACT_PEEK: begin
              if (flags_now.is_empty) begin
                imm_v = 1'b1;
                imm_s = lsp_pkg::STAT_EMPTY_ERR;
              end else if ((cw_pos == '0) || (cw_pos > cw_fill)) begin
                imm_v = 1'b1;
                imm_s = lsp_pkg::STAT_POS_ERR;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = peek_addr;
                state_d   = lsp_pkg::ST_READ;
              end
            end
            lsp_pkg::ACT_TOP: begin
              if (flags_now.is_empty) begin
                imm_v = 1'b1;
                imm_s = lsp_pkg::STAT_EMPTY_ERR;
              end else begin
                ram_re  = 1'b1;
                state_d = lsp_pkg::ST_READ;
              end
            end
            lsp_pkg::ACT_BOTTOM: begin
              if (flags_now.is_empty) begin
                imm_v = 1'b1;
                imm_s = lsp_pkg::STAT_EMPTY_ERR;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = lsp_pkg::ST_READ;
              end
            end
            lsp_pkg::ACT_DUMP: begin
              if (flags_now.is_empty) begin
                imm_v = 1'b1;
                imm_s = lsp_pkg::STAT_EMPTY_ERR;
              end else begin
                ram_re  = 1'b1;
                dump_d  = 1'b1;
                idx_d   = top_addr;
                state_d = lsp_pkg::ST_READ;
              end
            end
            default: begin
              // Status query, and the unused action code, report without changes.
              imm_v = 1'b1;
            end
          endcase
        end
      end
      lsp_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = rd_word;
          out_status_d = lsp_pkg::STAT_OK;
          out_flags_d  = flags_next;
          out_last_d   = !dump_q || (idx_q == '0);
          if (dump_q && (idx_q != '0)) begin
            // Fetch the next entry down while this one goes out.
            ram_re    = 1'b1;
            ram_raddr = idx_q - ADDR_W'(1);
            idx_d     = idx_q - ADDR_W'(1);
          end else begin
            state_d = lsp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lsp_pkg::ST_IDLE;
      end
    endcase

    if (imm_v) begin
      out_valid_d  = 1'b1;
      out_data_d   = '0;
      out_status_d = imm_s;
      out_flags_d  = flags_next;
      out_last_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lsp_pkg::CAP_RESET;
      state_q     <= lsp_pkg::ST_IDLE;
      fill_q      <= '0;
      dump_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      state_q     <= state_d;
      fill_q      <= fill_d;
      dump_q      <= dump_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_flags_q  <= out_flags_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign is_empty_o  = out_flags_q.is_empty;
  assign is_full_o   = out_flags_q.is_full;
  assign count_o     = out_flags_q.count;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  // The entry count never runs past the memory depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A write and a read never share a cycle, so no forwarding path is needed.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("memory written and read in the same cycle");

  // A pop on a non-empty stack removes exactly one entry.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == lsp_pkg::ACT_POP) && (fill_q != '0))
      |=> (fill_q == CNT_W'($past(fill_q) - CNT_W'(1))))
    else $error("pop did not decrement the count");

  // Loading the bottom entry of a dump ends the read sequence.
  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lsp_pkg::ST_READ) && dump_q && (idx_q == '0) && out_free)
      |=> (state_q == lsp_pkg::ST_IDLE) && out_valid_q && out_last_q)
    else $error("dump did not end on the bottom entry");
`endif

endmodule

`default_nettype wire

// ===== bench/lifo_stack_with_peek_core_tb.sv =====
`timescale 1ns / 100ps

module lifo_stack_with_peek_core_tb;

  localparam int STACK_DEPTH = 16;
  // The action field is three bits wide, so one code is left over; the block treats it
  // like a status query.
  localparam logic [2:0] ACT_SPARE = 3'd7;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

  // One result word as the block reports it.
  typedef struct packed {
    logic [31:0]       data;
    lsp_pkg::status_e  status;
    logic              is_empty;
    logic              is_full;
    logic [4:0]        count;
    logic              last;
  } result_word_t;

  // Shadow copy of the stack. Every accepted request is applied here, and the result
  // words that it should cause are queued in order. Each word that leaves the block is
  // checked against the oldest queued one.
  class stack_shadow;
    logic [31:0]  store[STACK_DEPTH];
    int unsigned  fill;
    logic [4:0]   capacity;
    result_word_t pending_words[$];
    int           mismatches;

    function new();
      fill = 0;
      capacity = lsp_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [4:0] value);
      capacity = value;
    endfunction

    // A capacity of zero behaves as one, and anything past the depth as the depth.
    function int unsigned cap_limit();
      if (capacity == 0) return 1;
      if (capacity > STACK_DEPTH) return STACK_DEPTH;
      return capacity;
    endfunction

    // The flags and the count are taken after the request has been applied.
    function void queue_word(logic [31:0] data, lsp_pkg::status_e status, logic last);
      result_word_t w;
      w.data = data;
      w.status = status;
      w.is_empty = (fill == 0);
      w.is_full = (fill >= cap_limit());
      w.count = fill[4:0];
      w.last = last;
      pending_words.push_back(w);
    endfunction

    function void note_request(logic [2:0] act, logic [31:0] value, logic [4:0] pos);
      int unsigned n;
      if (act != lsp_pkg::ACT_PUSH && act != lsp_pkg::ACT_STATUS && act != ACT_SPARE &&
          fill == 0) begin
        // Every read of an empty stack fails, a dump and a bad peek position included.
        queue_word('0, lsp_pkg::STAT_EMPTY_ERR, 1'b1);
        return;
      end
      case (act)
        lsp_pkg::ACT_PUSH: begin
          if (fill >= cap_limit()) begin
            queue_word('0, lsp_pkg::STAT_FULL_ERR, 1'b1);
          end else begin
            store[fill] = value;
            fill++;
            queue_word('0, lsp_pkg::STAT_OK, 1'b1);
          end
        end
        lsp_pkg::ACT_POP: begin
          fill--;
          queue_word(store[fill], lsp_pkg::STAT_OK, 1'b1);
        end
        lsp_pkg::ACT_PEEK: begin
          if (pos == 0 || pos > fill) queue_word('0, lsp_pkg::STAT_POS_ERR, 1'b1);
          else queue_word(store[fill - pos], lsp_pkg::STAT_OK, 1'b1);
        end
        lsp_pkg::ACT_TOP:    queue_word(store[fill - 1], lsp_pkg::STAT_OK, 1'b1);
        lsp_pkg::ACT_BOTTOM: queue_word(store[0], lsp_pkg::STAT_OK, 1'b1);
        lsp_pkg::ACT_DUMP: begin
          n = fill;
          for (int k = 0; k < n; k++) begin
            queue_word(store[n - 1 - k], lsp_pkg::STAT_OK, k == n - 1);
          end
        end
        default: queue_word('0, lsp_pkg::STAT_OK, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] wanted, logic [31:0] seen);
      if (seen !== wanted) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, wanted, seen);
        mismatches++;
      end
    endfunction

    function void check_word(result_word_t seen);
      result_word_t wanted;
      if (pending_words.size() == 0) begin
        $display("%0t: result word with no request waiting, data %0h status %0d",
                 $time, seen.data, seen.status);
        mismatches++;
        return;
      end
      wanted = pending_words.pop_front();
      compare_field("data", wanted.data, seen.data);
      compare_field("status", 32'(wanted.status), 32'(seen.status));
      compare_field("is_empty", 32'(wanted.is_empty), 32'(seen.is_empty));
      compare_field("is_full", 32'(wanted.is_full), 32'(seen.is_full));
      compare_field("count", 32'(wanted.count), 32'(seen.count));
      compare_field("last", 32'(wanted.last), 32'(seen.last));
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [lsp_pkg::CAP_W-1:0]         cfg_wdata_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [2:0]                        action_i = lsp_pkg::ACT_STATUS;
  logic signed [lsp_pkg::DATA_W-1:0] push_value_i = '0;
  logic [lsp_pkg::POS_W-1:0]         position_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [lsp_pkg::DATA_W-1:0] data_o;
  logic [1:0]                        status_o;
  logic                              is_empty_o;
  logic                              is_full_o;
  logic [lsp_pkg::COUNT_W-1:0]       count_o;
  logic                              last_o;

  stack_shadow shadow = new();

  lifo_stack_with_peek_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_o       (data_o),
    .status_o     (status_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .count_o      (count_o),
    .last_o       (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // All sampling happens at the rising edge, where every input driven at the falling
  // edge is settled and the block's own outputs still hold their pre-edge values. The
  // outgoing word is checked before the incoming request is noted; the two can never
  // belong together, since no result leaves in the cycle its request is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        shadow.check_word({data_o, lsp_pkg::status_e'(status_o), is_empty_o, is_full_o,
                           count_o, last_o});
      end
      if (cfg_we_i) shadow.set_capacity(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) shadow.note_request(action_i, push_value_i, position_i);
    end
  end

  // The receiver runs in stretches of random length, each with its own stall pattern:
  // never stalling, stalling now and then, stalling most of the time, or alternating.
  int stall_mode = 0;
  int stall_left = 0;
  logic stall_toggle = 1'b0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    stall_toggle = ~stall_toggle;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_toggle;
    endcase
  end

  // Offers one request word and holds it until the block takes it. The next call or an
  // idle call drives the following falling edge, so the valid is never lowered and raised
  // again within one step.
  task automatic send_request(logic [2:0] act, logic [31:0] value, logic [4:0] pos);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    push_value_i <= value;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Waits until every expected word has come out, then idles on so the block is fully at rest.
  task automatic wait_idle();
    idle_cycles(1);
    while (shadow.pending_words.size() > 0) @(negedge clk_i);
    idle_cycles(4);
  endtask

  task automatic write_capacity(logic [4:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return WORD_ONES;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic in bursts. With fill_bias set, pushes dominate and the stack climbs to
  // its limit; without it, pops dominate and the stack runs dry. Peek positions mostly
  // land inside the stack, with the rest spread over the whole field.
  task automatic random_phase(int n_items, bit fill_bias);
    int burst_left;
    int r;
    int push_share;
    logic [2:0] act;
    logic [4:0] pos;
    burst_left = 0;
    push_share = fill_bias ? 55 : 20;
    repeat (n_items) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        idle_cycles($urandom_range(0, 5));
      end
      burst_left--;
      r = $urandom_range(0, 99);
      if (r < push_share) begin
        act = lsp_pkg::ACT_PUSH;
      end else if (r < push_share + 25) begin
        act = lsp_pkg::ACT_POP;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: act = lsp_pkg::ACT_PEEK;
          8, 9:                   act = lsp_pkg::ACT_TOP;
          10, 11:                 act = lsp_pkg::ACT_BOTTOM;
          12, 13, 14:             act = lsp_pkg::ACT_DUMP;
          15, 16, 17, 18:         act = lsp_pkg::ACT_STATUS;
          default:                act = ACT_SPARE;
        endcase
      end
      if (shadow.fill > 0 && $urandom_range(0, 3) != 0) pos = $urandom_range(1, shadow.fill);
      else pos = $urandom_range(0, 31);
      send_request(act, pick_value(), pos);
    end
  endtask

  // Capacities for the random phases: the extremes, values outside the legal range on
  // both sides, and a few ordinary ones. Going from sixteen down to one after a filling and a
  // draining phase can leave the stack holding more than the new capacity.
  logic [4:0] phase_caps[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd10};

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_cycles(2);

    // Every read of an empty stack, the status query and the spare code, at the reset
    // capacity.
    send_request(lsp_pkg::ACT_POP, '0, 5'd1);
    send_request(lsp_pkg::ACT_PEEK, '0, 5'd0);
    send_request(lsp_pkg::ACT_TOP, '0, 5'd1);
    send_request(lsp_pkg::ACT_BOTTOM, '0, 5'd1);
    send_request(lsp_pkg::ACT_DUMP, '0, 5'd1);
    send_request(lsp_pkg::ACT_STATUS, '0, 5'd0);
    send_request(ACT_SPARE, WORD_ONES, 5'd31);

    // Push the extreme words, peek inside and outside the stack, then read the top and bottom, dump and pop.
    send_request(lsp_pkg::ACT_PUSH, WORD_MAX, 5'd0);
    send_request(lsp_pkg::ACT_PUSH, WORD_MIN, 5'd31);
    send_request(lsp_pkg::ACT_PUSH, WORD_ONES, 5'd0);
    send_request(lsp_pkg::ACT_PUSH, '0, 5'd0);
    send_request(lsp_pkg::ACT_PEEK, '0, 5'd0);
    send_request(lsp_pkg::ACT_PEEK, '0, 5'd1);
    send_request(lsp_pkg::ACT_PEEK, '0, 5'd4);
    send_request(lsp_pkg::ACT_PEEK, '0, 5'd5);
    send_request(lsp_pkg::ACT_PEEK, WORD_ONES, 5'd31);
    send_request(lsp_pkg::ACT_TOP, '0, 5'd0);
    send_request(lsp_pkg::ACT_BOTTOM, '0, 5'd0);
    send_request(lsp_pkg::ACT_DUMP, '0, 5'd0);
    send_request(lsp_pkg::ACT_POP, '0, 5'd0);

    // Lower the capacity below the three entries held: the stack reports full, refuses
    // pushes, and keeps refusing them after one pop since two is still the limit.
    write_capacity(5'd2);
    send_request(lsp_pkg::ACT_PUSH, 32'h1234_5678, 5'd0);
    send_request(lsp_pkg::ACT_STATUS, '0, 5'd0);
    send_request(lsp_pkg::ACT_POP, '0, 5'd0);
    send_request(lsp_pkg::ACT_PUSH, 32'h0bad_cafe, 5'd0);

    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      random_phase(27, 1'b1);
      random_phase(24, 1'b0);
    end

    wait_idle();
    idle_cycles(8);
    if (shadow.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run with every dump at full depth and the
  // receiver stalling as much as it can.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
